// File: hdl/csvt_pkg.sv
package csvt_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] SEPARATOR_RESET = 8'd44;

	// depth of the queue between front and back, at least 2
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		TK_CONTENT = 2'd0,
		TK_FIELD   = 2'd1,
		TK_ROW     = 2'd2,
		TK_END     = 2'd3
	} token_kind_t;

	// one queue entry: the token from the byte itself, then the optional
	// row flush and end marker that the last byte of a text adds
	typedef struct packed {
		logic        tok_v;
		token_kind_t tok_kind;
		logic [7:0]  tok_byte;
		logic        flush;
		logic        eot;
	} entry_t;

endpackage

// File: hdl/csvt_front.sv
module csvt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                separator_wr,
	input  logic [7:0]          separator,
	input  logic                accept,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	output logic                entry_push,
	output csvt_pkg::entry_t    entry
);

	logic [7:0] separator_q;
	logic       in_quotes_q;
	logic       quote_pending_q;
	logic       field_nonempty_q;
	logic       row_nonempty_q;

	logic in_quotes_n;
	logic quote_pending_n;
	logic field_nonempty_n;
	logic row_nonempty_n;
	logic use_outside;

	always_comb begin
		in_quotes_n      = in_quotes_q;
		quote_pending_n  = quote_pending_q;
		field_nonempty_n = field_nonempty_q;
		row_nonempty_n   = row_nonempty_q;
		use_outside      = 1'b0;
		entry.tok_v      = 1'b0;
		entry.tok_kind   = csvt_pkg::TK_CONTENT;
		entry.tok_byte   = 8'd0;
		entry.flush      = 1'b0;
		entry.eot        = end_of_text;

		priority if (quote_pending_q) begin
			quote_pending_n = 1'b0;
			if (text_byte == csvt_pkg::CH_QUOTE) begin
				entry.tok_v      = 1'b1;
				entry.tok_byte   = csvt_pkg::CH_QUOTE;
				field_nonempty_n = 1'b1;
			end else begin
				in_quotes_n = 1'b0;
				use_outside = 1'b1;
			end
		end else if (in_quotes_q) begin
			if (text_byte == csvt_pkg::CH_QUOTE) begin
				quote_pending_n = 1'b1;
			end else begin
				entry.tok_v      = 1'b1;
				entry.tok_byte   = text_byte;
				field_nonempty_n = 1'b1;
			end
		end else begin
			use_outside = 1'b1;
		end

		// quote beats separator, separator beats CR and LF
		if (use_outside) begin
			priority if (text_byte == csvt_pkg::CH_QUOTE) begin
				in_quotes_n = 1'b1;
			end else if (text_byte == separator_q) begin
				entry.tok_v      = 1'b1;
				entry.tok_kind   = csvt_pkg::TK_FIELD;
				field_nonempty_n = 1'b0;
				row_nonempty_n   = 1'b1;
			end else if (text_byte == csvt_pkg::CH_CR) begin
				entry.tok_v = 1'b0;
			end else if (text_byte == csvt_pkg::CH_LF) begin
				entry.tok_v      = 1'b1;
				entry.tok_kind   = csvt_pkg::TK_ROW;
				field_nonempty_n = 1'b0;
				row_nonempty_n   = 1'b0;
			end else begin
				entry.tok_v      = 1'b1;
				entry.tok_byte   = text_byte;
				field_nonempty_n = 1'b1;
			end
		end

		if (end_of_text) begin
			entry.flush      = field_nonempty_n | row_nonempty_n;
			in_quotes_n      = 1'b0;
			quote_pending_n  = 1'b0;
			field_nonempty_n = 1'b0;
			row_nonempty_n   = 1'b0;
		end
	end

	// drop bytes that yield no token
	assign entry_push = accept & (entry.tok_v | end_of_text);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q      <= csvt_pkg::SEPARATOR_RESET;
			in_quotes_q      <= 1'b0;
			quote_pending_q  <= 1'b0;
			field_nonempty_q <= 1'b0;
			row_nonempty_q   <= 1'b0;
		end else begin
			if (separator_wr) begin
				separator_q <= separator;
			end
			if (accept) begin
				in_quotes_q      <= in_quotes_n;
				quote_pending_q  <= quote_pending_n;
				field_nonempty_q <= field_nonempty_n;
				row_nonempty_q   <= row_nonempty_n;
			end
		end
	end

endmodule

// File: hdl/csvt_fifo.sv
module csvt_fifo #(
	parameter int DEPTH = csvt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  csvt_pkg::entry_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output csvt_pkg::entry_t rd_data,
	output logic             nonempty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	csvt_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & nonempty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/csvt_back.sv
module csvt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_v,
	input  csvt_pkg::entry_t head,
	output logic             head_pop,
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       token_kind,
	output logic [7:0]       content_byte,
	output logic             last_of_run
);

	typedef enum logic [2:0] {
		PH_TOK   = 3'b001,
		PH_FLUSH = 3'b010,
		PH_END   = 3'b100
	} phase_t;

	phase_t phase_q;
	phase_t phase_n;

	logic                  out_v_q;
	csvt_pkg::token_kind_t kind_q;
	logic [7:0]            byte_q;
	logic                  last_q;

	logic                  sel_tok;
	logic                  sel_flush;
	logic                  advance;
	csvt_pkg::token_kind_t cur_kind;
	logic [7:0]            cur_byte;
	logic                  cur_last;

	// pick the first token of the head entry still owed from the current phase
	always_comb begin
		sel_tok   = (phase_q == PH_TOK) && head.tok_v;
		sel_flush = !sel_tok && (phase_q != PH_END) && head.flush;
		priority if (sel_tok) begin
			cur_kind = head.tok_kind;
			cur_byte = head.tok_byte;
			cur_last = !head.flush && !head.eot;
			phase_n  = head.flush ? PH_FLUSH : PH_END;
		end else if (sel_flush) begin
			cur_kind = csvt_pkg::TK_ROW;
			cur_byte = 8'd0;
			cur_last = 1'b0;
			phase_n  = PH_END;
		end else begin
			cur_kind = csvt_pkg::TK_END;
			cur_byte = 8'd0;
			cur_last = 1'b1;
			phase_n  = PH_TOK;
		end
		if (cur_last) begin
			phase_n = PH_TOK;
		end
	end

	assign advance  = head_v && (!out_v_q || pop);
	assign head_pop = advance && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOK;
			out_v_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_n;
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// hold the waiting result until its transfer
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= cur_kind;
			byte_q <= cur_byte;
			last_q <= cur_last;
		end
	end

	assign empty        = !out_v_q;
	assign token_kind   = kind_q;
	assign content_byte = byte_q;
	assign last_of_run  = last_q;

endmodule

// File: hdl/csv_field_tokenizer.sv
// CSV tokenizer: takes one text byte per cycle (push/full) and gives one token per cycle
// (empty/pop): content bytes, end of field, end of field and row, end of text. Quoted
// fields and doubled quotes follow RFC 4180, and CR outside quotes is dropped; separator_wr
// loads the separator (reset ','), to be written by the user only while the block is idle,
// which the block itself does not enforce. The tokens of an accepted byte pass through the
// queue and the registered output of the back end, which drains the queue one token per
// cycle while the consumer pops; the last byte of a text gives up to three tokens. Bytes
// that give no token (CR, quotes) are not queued unless they end a text. full rises only
// when the QUEUE_DEPTH-entry queue (at least 2) between classifier and token emitter fills
// because of a stalled consumer, or because final bytes, each adding up to two extra
// tokens, arrive in a burst faster than the back end drains them.
module csv_field_tokenizer #(
	parameter int QUEUE_DEPTH = csvt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       separator_wr,
	input  logic [7:0] separator,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] token_kind,
	output logic [7:0] content_byte,
	output logic       last_of_run
);

	logic             accept;
	logic             entry_push;
	csvt_pkg::entry_t entry;
	logic             head_v;
	csvt_pkg::entry_t head;
	logic             head_pop;

	assign accept = push & ~full;

	csvt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.separator_wr (separator_wr),
		.separator    (separator),
		.accept       (accept),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.entry_push   (entry_push),
		.entry        (entry)
	);

	csvt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (entry_push),
		.wr_data  (entry),
		.full     (full),
		.rd_en    (head_pop),
		.rd_data  (head),
		.nonempty (head_v)
	);

	csvt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_v       (head_v),
		.head         (head),
		.head_pop     (head_pop),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.content_byte (content_byte),
		.last_of_run  (last_of_run)
	);

`ifndef ASSERT_OFF
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind == csvt_pkg::TK_END) |-> last_of_run)
		else $error("end-of-text token not marked last");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind != csvt_pkg::TK_CONTENT) |-> (content_byte == 8'd0))
		else $error("non-content token carries a byte");

	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		entry_push |-> (entry.tok_v || entry.eot))
		else $error("queue entry with no token");
`endif

endmodule

// File: tb/csv_field_tokenizer_test.sv
`timescale 1ns / 1ps

module csv_field_tokenizer_test;

	typedef struct packed {
		logic [7:0] b;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		csvt_pkg::token_kind_t kind;
		logic [7:0]            data;
		logic                  last;
	} token_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       separator_wr = 1'b0;
	logic [7:0] separator = csvt_pkg::SEPARATOR_RESET;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [1:0] token_kind;
	logic [7:0] content_byte;
	logic       last_of_run;

	csv_field_tokenizer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.separator_wr(separator_wr),
		.separator(separator),
		.push(push),
		.full(full),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.empty(empty),
		.pop(pop),
		.token_kind(token_kind),
		.content_byte(content_byte),
		.last_of_run(last_of_run)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// bytes waiting to be offered, and tokens still owed by the block
	text_item_t text_queue[$];
	token_t     expected_tokens[$];
	token_t     run_tokens[$];
	token_t     head;

	// tokenizer state as predicted
	logic [7:0] cur_sep = csvt_pkg::SEPARATOR_RESET;
	logic       quoted = 1'b0;
	logic       quote_held = 1'b0;
	logic       field_has_data = 1'b0;
	logic       row_has_field = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_taken = 0;
	int bytes_dropped = 0;
	int tokens_checked = 0;
	int texts_closed = 0;
	int stall_cycles = 0;
	int errors = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	task automatic flag(input string msg);
		errors++;
		$display("mismatch %0d: %s", errors, msg);
	endtask

	function automatic void add_token(input csvt_pkg::token_kind_t k, input logic [7:0] b);
		token_t t;
		t.kind = k;
		t.data = (k == csvt_pkg::TK_CONTENT) ? b : 8'h00;
		t.last = 1'b0;
		run_tokens.push_back(t);
	endfunction

	// byte seen outside quotes
	function automatic void take_plain(input logic [7:0] c);
		if (c == csvt_pkg::CH_QUOTE) begin
			quoted = 1'b1;
		end else if (c == cur_sep) begin
			add_token(csvt_pkg::TK_FIELD, 8'h00);
			field_has_data = 1'b0;
			row_has_field = 1'b1;
		end else if (c == csvt_pkg::CH_CR) begin
			// drop
		end else if (c == csvt_pkg::CH_LF) begin
			add_token(csvt_pkg::TK_ROW, 8'h00);
			field_has_data = 1'b0;
			row_has_field = 1'b0;
		end else begin
			add_token(csvt_pkg::TK_CONTENT, c);
			field_has_data = 1'b1;
		end
	endfunction

	function automatic void predict_tokens(input logic [7:0] c, input logic eot);
		token_t t;
		run_tokens.delete();
		if (quote_held) begin
			quote_held = 1'b0;
			if (c == csvt_pkg::CH_QUOTE) begin
				add_token(csvt_pkg::TK_CONTENT, csvt_pkg::CH_QUOTE);
				field_has_data = 1'b1;
			end else begin
				quoted = 1'b0;
				take_plain(c);
			end
		end else if (quoted) begin
			if (c == csvt_pkg::CH_QUOTE) begin
				quote_held = 1'b1;
			end else begin
				add_token(csvt_pkg::TK_CONTENT, c);
				field_has_data = 1'b1;
			end
		end else begin
			take_plain(c);
		end
		if (eot) begin
			if (field_has_data || row_has_field)
				add_token(csvt_pkg::TK_ROW, 8'h00);
			add_token(csvt_pkg::TK_END, 8'h00);
			quoted = 1'b0;
			quote_held = 1'b0;
			field_has_data = 1'b0;
			row_has_field = 1'b0;
			texts_closed++;
		end
		foreach (run_tokens[i]) begin
			t = run_tokens[i];
			t.last = (i == run_tokens.size() - 1);
			expected_tokens.push_back(t);
		end
	endfunction

	// sample both transfers at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && full)
				stall_cycles++;
			if (push && !full) begin
				predict_tokens(text_byte, end_of_text);
				bytes_taken++;
			end
			if (pop && !empty) begin
				if (expected_tokens.size() == 0) begin
					flag($sformatf("token kind %0d with none expected", token_kind));
				end else begin
					head = expected_tokens.pop_front();
					tokens_checked++;
					if (token_kind !== head.kind)
						flag($sformatf("token %0d kind %0d, expected %0d",
							tokens_checked, token_kind, head.kind));
					if (content_byte !== head.data)
						flag($sformatf("token %0d byte %02h, expected %02h",
							tokens_checked, content_byte, head.data));
					if (last_of_run !== head.last)
						flag($sformatf("token %0d last_of_run %0b, expected %0b",
							tokens_checked, last_of_run, head.last));
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = 150;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	always @(negedge clk) begin
		logic offer;
		// drop the byte transferred at the last rising edge
		while (bytes_dropped < bytes_taken) begin
			void'(text_queue.pop_front());
			bytes_dropped++;
		end
		offer = arst_n && text_queue.size() > 0 &&
			$urandom_range(99) >= send_idle_pct;
		push <= offer;
		if (offer) begin
			text_byte <= text_queue[0].b;
			end_of_text <= text_queue[0].eot;
		end else begin
			text_byte <= 8'($urandom_range(255));
			end_of_text <= 1'($urandom_range(1));
		end
	end

	always @(negedge clk) begin
		pop <= arst_n && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
	end

	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			text_queue.push_back('{s[i], close && i == s.len() - 1});
	endtask

	// hold until every byte is taken and every token has come, then let the pipe drain
	task automatic settle();
		while (text_queue.size() != 0 || expected_tokens.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_separator(input logic [7:0] v);
		settle();
		separator_wr <= 1'b1;
		separator <= v;
		cur_sep = v;
		@(negedge clk);
		separator_wr <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_plain();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == csvt_pkg::CH_QUOTE || b == cur_sep || b == csvt_pkg::CH_CR ||
			b == csvt_pkg::CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] pick_any();
		case ($urandom_range(9))
			0: return csvt_pkg::CH_QUOTE;
			1: return cur_sep;
			2: return csvt_pkg::CH_CR;
			3: return csvt_pkg::CH_LF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_random_texts(input int budget);
		logic [7:0] txt[$];
		logic [7:0] b;
		int added;
		bit close;
		added = 0;
		while (added < budget) begin
			txt.delete();
			close = 1'b1;
			if ($urandom_range(99) < 80) begin
				for (int r = $urandom_range(1, 3); r > 0; r--) begin
					for (int f = $urandom_range(1, 4); f > 0; f--) begin
						if ($urandom_range(1)) begin
							txt.push_back(csvt_pkg::CH_QUOTE);
							for (int n = $urandom_range(4); n > 0; n--) begin
								case ($urandom_range(9))
									0: begin
										txt.push_back(csvt_pkg::CH_QUOTE);
										txt.push_back(csvt_pkg::CH_QUOTE);
									end
									1: txt.push_back(cur_sep);
									2: txt.push_back(csvt_pkg::CH_CR);
									3: txt.push_back(csvt_pkg::CH_LF);
									default: begin
										do
											b = 8'($urandom_range(255));
										while (b == csvt_pkg::CH_QUOTE);
										txt.push_back(b);
									end
								endcase
							end
							txt.push_back(csvt_pkg::CH_QUOTE);
						end else begin
							for (int n = $urandom_range(4); n > 0; n--)
								txt.push_back(pick_plain());
						end
						if (f > 1)
							txt.push_back(cur_sep);
					end
					if (r > 1 || $urandom_range(1)) begin
						if ($urandom_range(2) == 0)
							txt.push_back(csvt_pkg::CH_CR);
						txt.push_back(csvt_pkg::CH_LF);
					end
				end
			end else begin
				// noise, often left open into the next text
				for (int n = $urandom_range(1, 8); n > 0; n--)
					txt.push_back(pick_any());
				close = 1'($urandom_range(1));
			end
			if (txt.size() == 0)
				txt.push_back(pick_plain());
			foreach (txt[i])
				text_queue.push_back('{txt[i], close && i == txt.size() - 1});
			added += txt.size();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset separator: quoted separator, doubled quote, CR dropped, LF
		send_text("a,\"x,\"\"\"\r\n", 1'b0);
		// quote in mid-field, CR inside quotes kept, closing quote then content
		send_text("q\"\r\"z", 1'b0);
		text_queue.push_back('{8'h00, 1'b0});
		text_queue.push_back('{8'hFF, 1'b0});
		// pending quote on the last byte closes, then flush
		send_text("\"k\"", 1'b1);
		// quotes only: no flush
		send_text("\"\"", 1'b1);
		// separator as last byte: field, flush, end
		send_text(",", 1'b1);
		send_text("\r", 1'b1);

		write_separator(csvt_pkg::CH_QUOTE);
		send_text("a\"b\"\n", 1'b1);
		write_separator(csvt_pkg::CH_CR);
		send_text("a\r\"\r\"\n", 1'b1);
		write_separator(csvt_pkg::CH_LF);
		send_text("b\n", 1'b1);

		write_separator(8'd59);
		send_idle_pct = 9;
		recv_idle_pct = 85;
		queue_random_texts(70);

		write_separator(8'h00);
		send_idle_pct = 85;
		recv_idle_pct = 9;
		queue_random_texts(70);

		write_separator(8'hFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_texts(30);
		settle();
		// stall the receiver while bytes keep coming, to fill the block
		hold_asks++;
		queue_random_texts(40);
		settle();
		write_separator(csvt_pkg::SEPARATOR_RESET);
		queue_random_texts(20);
		settle();

		$display("covered %0d bytes in %0d closed texts, %0d tokens checked,",
			bytes_taken, texts_closed, tokens_checked);
		$display("separators , \" CR LF ; 00 FF, %0d cycles with input held by full",
			stall_cycles);
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("[csv_field_tokenizer] OK");
		end else begin
			$display("[csv_field_tokenizer] ERROR");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d tokens outstanding", expected_tokens.size());
		$display("[csv_field_tokenizer] ERROR");
		$finish;
	end

endmodule
